FILE: hw/rtl/skt_pkg.sv
// Shared constants and types for the snapshot new-key tracker.
`timescale 1ns / 1ps

package skt_pkg;

  localparam int TABLE_DEPTH_DEF = 512;
  localparam int KEY_WIDTH_DEF   = 64;
  localparam int COUNT_OUT_W     = 10;

  typedef enum logic [2:0] {
    ACT_ARM    = 3'd0,
    ACT_SCAN   = 3'd1,
    ACT_END    = 3'd2,
    ACT_QUERY  = 3'd3,
    ACT_REMOVE = 3'd4,
    ACT_CLEAR  = 3'd5
  } act_t;

endpackage

FILE: hw/rtl/skt_ram.sv
// Simple dual-port table memory with a registered read.
`timescale 1ns / 1ps

module skt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rq
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rq <= mem[ra];
  end

endmodule

FILE: hw/rtl/snapshot_new_key_tracker.sv
// Top level of the snapshot new-key tracker: sequencer over three key tables.
`timescale 1ns / 1ps

// Command-style block: pulse start with action/key/in_primary while busy is
// low; exactly one result word follows on a one-cycle done strobe, and the
// receiver cannot stall it. The three tables (seen, current, new) each sit in
// a one-port-read memory, and every table visit is a read (address), then a
// compare. Scan, query and remove each walk one table. End of scan walks the
// tables: without a baseline it only copies current into seen; with one, a
// prune pass drops new keys no longer in the primary part of current, an add
// pass puts primary current keys found in neither seen nor new into new, and
// then current is copied into seen.
module snapshot_new_key_tracker #(
  parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = skt_pkg::KEY_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           action,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic                 in_primary,
  output logic                 done,
  output logic                 is_new,
  output logic                 changed,
  output logic [9:0]           new_count,
  output logic                 overflow
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE     = CW'(1);

  typedef enum logic [27:0] {
    ST_IDLE     = 28'h0000001,
    ST_SCAN_RD  = 28'h0000002,
    ST_SCAN_CMP = 28'h0000004,
    ST_QRY_RD   = 28'h0000008,
    ST_QRY_CMP  = 28'h0000010,
    ST_RM_RD    = 28'h0000020,
    ST_RM_WR    = 28'h0000040,
    ST_PR_RD    = 28'h0000080,
    ST_PR_KEY   = 28'h0000100,
    ST_PS_RD    = 28'h0000200,
    ST_PS_CMP   = 28'h0000400,
    ST_PM_RD    = 28'h0000800,
    ST_PM_WR    = 28'h0001000,
    ST_AD_BEGIN = 28'h0002000,
    ST_AD_RD    = 28'h0004000,
    ST_AD_KEY   = 28'h0008000,
    ST_AS_RD    = 28'h0010000,
    ST_AS_CMP   = 28'h0020000,
    ST_AN_BEGIN = 28'h0040000,
    ST_AN_RD    = 28'h0080000,
    ST_AN_CMP   = 28'h0100000,
    ST_AD_INS   = 28'h0200000,
    ST_AD_NEXT  = 28'h0400000,
    ST_CP_BEGIN = 28'h0800000,
    ST_CP_RD    = 28'h1000000,
    ST_CP_WR    = 28'h2000000,
    ST_CP_END   = 28'h4000000,
    ST_DONE     = 28'h8000000
  } state_t;

  state_t               state, state_next;
  logic [CW-1:0]        i, i_next, j, j_next, pos, pos_next;
  logic [CW-1:0]        cc, cc_next, nc, nc_next, sc, sc_next;
  logic                 base, base_next;
  logic [KEY_WIDTH-1:0] owner, owner_next, key_r, key_r_next, k, k_next;
  skt_pkg::act_t        act, act_next;
  logic                 prim_r, prim_r_next;
  logic                 chg, chg_next, ovf, ovf_next, isn, isn_next;

  logic                 cur_we, seen_we, new_we;
  logic [AW-1:0]        cur_wa, seen_wa, new_wa, cur_ra, seen_ra, new_ra;
  logic [KEY_WIDTH:0]   cur_wd, cur_q;
  logic [KEY_WIDTH-1:0] seen_wd, seen_q, new_wd, new_q;
  logic [CW+9:0]        nc_ext;

  skt_ram #(.WIDTH(KEY_WIDTH + 1), .DEPTH(TABLE_DEPTH)) u_cur (
    .clk(clk), .we(cur_we), .wa(cur_wa), .wd(cur_wd), .ra(cur_ra), .rq(cur_q)
  );
  skt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLE_DEPTH)) u_seen (
    .clk(clk), .we(seen_we), .wa(seen_wa), .wd(seen_wd), .ra(seen_ra), .rq(seen_q)
  );
  skt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLE_DEPTH)) u_new (
    .clk(clk), .we(new_we), .wa(new_wa), .wd(new_wd), .ra(new_ra), .rq(new_q)
  );

  assign busy   = (state != ST_IDLE);
  assign nc_ext = {10'b0, nc};

  assign cur_ra  = (state == ST_AD_RD || state == ST_CP_RD) ? i[AW-1:0] : j[AW-1:0];
  assign seen_ra = j[AW-1:0];
  always_comb begin
    if (state == ST_RM_RD || state == ST_PM_RD) begin
      new_ra = nc[AW-1:0];
    end else if (state == ST_PR_RD) begin
      new_ra = i[AW-1:0];
    end else begin
      new_ra = j[AW-1:0];
    end
  end

  always_comb begin
    state_next  = state;
    i_next      = i;
    j_next      = j;
    pos_next    = pos;
    cc_next     = cc;
    nc_next     = nc;
    sc_next     = sc;
    base_next   = base;
    owner_next  = owner;
    key_r_next  = key_r;
    k_next      = k;
    act_next    = act;
    prim_r_next = prim_r;
    chg_next    = chg;
    ovf_next    = ovf;
    isn_next    = isn;
    cur_we      = 1'b0;
    cur_wa      = cc[AW-1:0];
    cur_wd      = {prim_r, key_r};
    seen_we     = 1'b0;
    seen_wa     = i[AW-1:0];
    seen_wd     = cur_q[KEY_WIDTH-1:0];
    new_we      = 1'b0;
    new_wa      = nc[AW-1:0];
    new_wd      = k;

    case (state)
      ST_IDLE: begin
        if (start) begin
          act_next    = skt_pkg::act_t'(action);
          key_r_next  = key;
          prim_r_next = in_primary;
          chg_next    = 1'b0;
          ovf_next    = 1'b0;
          isn_next    = 1'b0;
          j_next      = '0;
          i_next      = '0;
          state_next  = ST_DONE;
          case (skt_pkg::act_t'(action))
            skt_pkg::ACT_ARM: begin
              if (key != '0 && key != owner) begin
                owner_next = key;
                sc_next    = '0;
                cc_next    = '0;
                nc_next    = '0;
                base_next  = 1'b0;
              end
            end
            skt_pkg::ACT_SCAN: begin
              if (key != '0) begin
                // empty table: go straight to the insert decision
                state_next = (cc == '0) ? ST_AD_INS : ST_SCAN_RD;
              end
            end
            skt_pkg::ACT_END: begin
              if (!base) begin
                chg_next   = (nc != '0);
                nc_next    = '0;
                base_next  = 1'b1;
                state_next = ST_CP_BEGIN;
              end else begin
                state_next = (nc == '0) ? ST_AD_BEGIN : ST_PR_RD;
              end
            end
            skt_pkg::ACT_QUERY, skt_pkg::ACT_REMOVE: begin
              if (key != '0 && nc != '0) begin
                state_next = ST_QRY_RD;
              end
            end
            skt_pkg::ACT_CLEAR: begin
              chg_next = (nc != '0);
              nc_next  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN_RD: state_next = ST_SCAN_CMP;

      ST_SCAN_CMP: begin
        if (cur_q[KEY_WIDTH-1:0] == key_r) begin
          if (prim_r) begin
            cur_we = 1'b1;
            cur_wa = j[AW-1:0];
            cur_wd = {1'b1, key_r};
          end
          state_next = ST_DONE;
        end else if (j + ONE < cc) begin
          j_next     = j + ONE;
          state_next = ST_SCAN_RD;
        end else begin
          state_next = ST_AD_INS;
        end
      end

      ST_QRY_RD: state_next = ST_QRY_CMP;

      ST_QRY_CMP: begin
        if (new_q == key_r) begin
          if (act == skt_pkg::ACT_QUERY) begin
            isn_next   = 1'b1;
            state_next = ST_DONE;
          end else begin
            pos_next   = j;
            nc_next    = nc - ONE;
            state_next = ST_RM_RD;
          end
        end else if (j + ONE < nc) begin
          j_next     = j + ONE;
          state_next = ST_QRY_RD;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_RM_RD: state_next = ST_RM_WR;

      ST_RM_WR: begin
        // move the last entry into the hole
        new_we     = 1'b1;
        new_wa     = pos[AW-1:0];
        new_wd     = new_q;
        chg_next   = 1'b1;
        state_next = ST_DONE;
      end

      ST_PR_RD: state_next = ST_PR_KEY;

      ST_PR_KEY: begin
        k_next = new_q;
        j_next = '0;
        if (cc == '0) begin
          nc_next    = nc - ONE;
          chg_next   = 1'b1;
          state_next = ST_PM_RD;
        end else begin
          state_next = ST_PS_RD;
        end
      end

      ST_PS_RD: state_next = ST_PS_CMP;

      ST_PS_CMP: begin
        if (cur_q[KEY_WIDTH] && cur_q[KEY_WIDTH-1:0] == k) begin
          i_next     = i + ONE;
          state_next = (i + ONE < nc) ? ST_PR_RD : ST_AD_BEGIN;
        end else if (j + ONE < cc) begin
          j_next     = j + ONE;
          state_next = ST_PS_RD;
        end else begin
          // drop: not in the primary part any more
          nc_next    = nc - ONE;
          chg_next   = 1'b1;
          state_next = ST_PM_RD;
        end
      end

      ST_PM_RD: state_next = ST_PM_WR;

      ST_PM_WR: begin
        new_we     = 1'b1;
        new_wa     = i[AW-1:0];
        new_wd     = new_q;
        state_next = (i < nc) ? ST_PR_RD : ST_AD_BEGIN;
      end

      ST_AD_BEGIN: begin
        i_next     = '0;
        state_next = (cc == '0) ? ST_CP_BEGIN : ST_AD_RD;
      end

      ST_AD_RD: state_next = ST_AD_KEY;

      ST_AD_KEY: begin
        k_next = cur_q[KEY_WIDTH-1:0];
        j_next = '0;
        if (!cur_q[KEY_WIDTH]) begin
          state_next = ST_AD_NEXT;
        end else if (sc == '0) begin
          state_next = ST_AN_BEGIN;
        end else begin
          state_next = ST_AS_RD;
        end
      end

      ST_AS_RD: state_next = ST_AS_CMP;

      ST_AS_CMP: begin
        if (seen_q == k) begin
          state_next = ST_AD_NEXT;
        end else if (j + ONE < sc) begin
          j_next     = j + ONE;
          state_next = ST_AS_RD;
        end else begin
          state_next = ST_AN_BEGIN;
        end
      end

      ST_AN_BEGIN: begin
        j_next     = '0;
        state_next = (nc == '0) ? ST_AD_INS : ST_AN_RD;
      end

      ST_AN_RD: state_next = ST_AN_CMP;

      ST_AN_CMP: begin
        if (new_q == k) begin
          state_next = ST_AD_NEXT;
        end else if (j + ONE < nc) begin
          j_next     = j + ONE;
          state_next = ST_AN_RD;
        end else begin
          state_next = ST_AD_INS;
        end
      end

      ST_AD_INS: begin
        // shared by scan insert and end-of-scan flagging
        if (act == skt_pkg::ACT_SCAN) begin
          if (cc == DEPTH_C) begin
            ovf_next = 1'b1;
          end else begin
            cur_we  = 1'b1;
            cc_next = cc + ONE;
          end
          state_next = ST_DONE;
        end else begin
          if (nc == DEPTH_C) begin
            ovf_next = 1'b1;
          end else begin
            new_we   = 1'b1;
            nc_next  = nc + ONE;
            chg_next = 1'b1;
          end
          state_next = ST_AD_NEXT;
        end
      end

      ST_AD_NEXT: begin
        if (i + ONE < cc) begin
          i_next     = i + ONE;
          state_next = ST_AD_RD;
        end else begin
          state_next = ST_CP_BEGIN;
        end
      end

      ST_CP_BEGIN: begin
        i_next     = '0;
        state_next = (cc == '0) ? ST_CP_END : ST_CP_RD;
      end

      ST_CP_RD: state_next = ST_CP_WR;

      ST_CP_WR: begin
        seen_we = 1'b1;
        if (i + ONE < cc) begin
          i_next     = i + ONE;
          state_next = ST_CP_RD;
        end else begin
          state_next = ST_CP_END;
        end
      end

      ST_CP_END: begin
        sc_next    = cc;
        cc_next    = '0;
        state_next = ST_DONE;
      end

      ST_DONE: state_next = ST_IDLE;

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cc    <= '0;
      nc    <= '0;
      sc    <= '0;
      base  <= 1'b0;
      owner <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cc    <= cc_next;
      nc    <= nc_next;
      sc    <= sc_next;
      base  <= base_next;
      owner <= owner_next;
      done  <= (state == ST_DONE);
    end
    i      <= i_next;
    j      <= j_next;
    pos    <= pos_next;
    key_r  <= key_r_next;
    k      <= k_next;
    act    <= act_next;
    prim_r <= prim_r_next;
    chg    <= chg_next;
    ovf    <= ovf_next;
    isn    <= isn_next;
    if (state == ST_DONE) begin
      is_new    <= isn;
      changed   <= chg;
      overflow  <= ovf;
      new_count <= nc_ext[9:0];
    end
  end

`ifndef ASSERT_OFF
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_DONE))
    else $error("result strobe without a finished command");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_new_bound: assert property (@(posedge clk) disable iff (rst)
    nc <= DEPTH_C && cc <= DEPTH_C && sc <= DEPTH_C)
    else $error("table count beyond depth");

  a_count_word: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> new_count == $past(nc_ext[9:0]))
    else $error("result count does not match new table");
`endif

endmodule

FILE: test/snapshot_new_key_tracker_tb.sv
// Self-checking testbench for the snapshot new-key tracker.
`timescale 1ns / 1ps

module snapshot_new_key_tracker_tb;

  localparam int DEPTH = skt_pkg::TABLE_DEPTH_DEF;

  typedef struct {
    logic [2:0]  action;
    logic [63:0] key;
    logic        prim;
    bit          drain;
  } cmd_t;

  typedef struct {
    logic       is_new;
    logic       changed;
    logic [9:0] new_count;
    logic       overflow;
  } word_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  action;
  logic [63:0] key;
  logic        in_primary;
  logic        done;
  logic        is_new;
  logic        changed;
  logic [9:0]  new_count;
  logic        overflow;

  snapshot_new_key_tracker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .key(key),
    .in_primary(in_primary), .done(done), .is_new(is_new), .changed(changed),
    .new_count(new_count), .overflow(overflow)
  );

  // tracker state as predicted
  logic [63:0] seen_tab[$];
  logic [63:0] cur_tab[$];
  bit          cur_prim[$];
  logic [63:0] new_tab[$];
  bit          has_baseline;
  logic [63:0] owner;

  cmd_t        cmd_q[$];
  word_t       expected_words[$];
  int          mismatches;
  int          burst_left;
  int          gap_left;
  logic [63:0] key_pool[24];

  function automatic int find_in(ref logic [63:0] tab[$], input logic [63:0] k);
    foreach (tab[i]) if (tab[i] == k) return i;
    return -1;
  endfunction

  function automatic bit in_primary_part(logic [63:0] k);
    foreach (cur_tab[i]) if (cur_prim[i] && cur_tab[i] == k) return 1;
    return 0;
  endfunction

  function automatic word_t track_cmd(cmd_t c);
    word_t w;
    int    pos;
    int    i;
    w = '{0, 0, 0, 0};
    case (c.action)
      skt_pkg::ACT_ARM: begin
        if (c.key != 0 && c.key != owner) begin
          owner = c.key;
          seen_tab.delete(); cur_tab.delete(); cur_prim.delete(); new_tab.delete();
          has_baseline = 0;
        end
      end
      skt_pkg::ACT_SCAN: begin
        if (c.key != 0) begin
          pos = find_in(cur_tab, c.key);
          if (pos >= 0) begin
            if (c.prim) cur_prim[pos] = 1;
          end else if (cur_tab.size() >= DEPTH) begin
            w.overflow = 1;
          end else begin
            cur_tab.push_back(c.key);
            cur_prim.push_back(c.prim);
          end
        end
      end
      skt_pkg::ACT_END: begin
        if (!has_baseline) begin
          w.changed = new_tab.size() > 0;
          new_tab.delete();
          has_baseline = 1;
        end else begin
          i = 0;
          // prune by swapping the last entry into the hole
          while (i < new_tab.size()) begin
            if (!in_primary_part(new_tab[i])) begin
              new_tab[i] = new_tab[new_tab.size()-1];
              void'(new_tab.pop_back());
              w.changed = 1;
            end else i++;
          end
          foreach (cur_tab[j]) begin
            if (!cur_prim[j] || find_in(seen_tab, cur_tab[j]) >= 0) continue;
            if (find_in(new_tab, cur_tab[j]) >= 0) continue;
            if (new_tab.size() >= DEPTH) begin
              w.overflow = 1;
              continue;
            end
            new_tab.push_back(cur_tab[j]);
            w.changed = 1;
          end
        end
        seen_tab = cur_tab;
        cur_tab.delete();
        cur_prim.delete();
      end
      skt_pkg::ACT_QUERY: w.is_new = c.key != 0 && find_in(new_tab, c.key) >= 0;
      skt_pkg::ACT_REMOVE: begin
        if (c.key != 0) begin
          pos = find_in(new_tab, c.key);
          if (pos >= 0) begin
            new_tab[pos] = new_tab[new_tab.size()-1];
            void'(new_tab.pop_back());
            w.changed = 1;
          end
        end
      end
      skt_pkg::ACT_CLEAR: begin
        if (new_tab.size() > 0) begin
          new_tab.delete();
          w.changed = 1;
        end
      end
      default: ;
    endcase
    w.new_count = 10'(new_tab.size());
    return w;
  endfunction

  task automatic add_cmd(logic [2:0] a, logic [63:0] k, logic p, bit d = 0);
    cmd_t c;
    c.action = a; c.key = k; c.prim = p; c.drain = d;
    cmd_q.push_back(c);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, exp);
    mismatches++;
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  // driver: present commands from the queue in bursts, hold while busy
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
      action <= skt_pkg::ACT_ARM;
      key <= 0;
      in_primary <= 0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (start && !busy) expected_words.push_back(track_cmd('{action, key, in_primary, 0}));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 0;
        end else if (cmd_q.size() > 0 && !(cmd_q[0].drain && expected_words.size() > 0)) begin
          action <= cmd_q[0].action;
          key <= cmd_q[0].key;
          in_primary <= cmd_q[0].prim;
          void'(cmd_q.pop_front());
          start <= 1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else burst_left <= burst_left - 1;
        end else start <= 0;
      end
    end
  end

  // monitor: every done strobe carries one word
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        if (is_new !== expected_words[0].is_new)
          report_mismatch("is_new", is_new, expected_words[0].is_new);
        if (changed !== expected_words[0].changed)
          report_mismatch("changed", changed, expected_words[0].changed);
        if (new_count !== expected_words[0].new_count)
          report_mismatch("new_count", new_count, expected_words[0].new_count);
        if (overflow !== expected_words[0].overflow)
          report_mismatch("overflow", overflow, expected_words[0].overflow);
        void'(expected_words.pop_front());
      end
    end
  end

  initial begin
    int n;
    int r;
    logic [63:0] k;
    mismatches = 0;
    has_baseline = 0;
    owner = 0;
    rst = 1;
    start = 0;
    action = skt_pkg::ACT_ARM;
    key = 0;
    in_primary = 0;

    // directed
    add_cmd(skt_pkg::ACT_ARM, 0, 0);
    add_cmd(skt_pkg::ACT_ARM, '1, 1);
    add_cmd(skt_pkg::ACT_ARM, '1, 0);
    add_cmd(skt_pkg::ACT_SCAN, 0, 1);
    add_cmd(skt_pkg::ACT_SCAN, '1, 0);
    add_cmd(skt_pkg::ACT_SCAN, 64'h1, 1);
    add_cmd(skt_pkg::ACT_END, 0, 0);
    add_cmd(skt_pkg::ACT_SCAN, '1, 0);
    add_cmd(skt_pkg::ACT_SCAN, 64'h8000_0000_0000_0000, 0);
    add_cmd(skt_pkg::ACT_SCAN, 64'h8000_0000_0000_0000, 1);
    add_cmd(skt_pkg::ACT_SCAN, 64'h5555_aaaa_5555_aaaa, 1);
    add_cmd(skt_pkg::ACT_END, '1, 1);
    add_cmd(skt_pkg::ACT_QUERY, 64'h8000_0000_0000_0000, 0);
    add_cmd(skt_pkg::ACT_QUERY, 0, 0);
    add_cmd(skt_pkg::ACT_QUERY, '1, 1);
    add_cmd(skt_pkg::ACT_REMOVE, 0, 0);
    add_cmd(skt_pkg::ACT_REMOVE, 64'h5555_aaaa_5555_aaaa, 0);
    add_cmd(skt_pkg::ACT_REMOVE, 64'h1234, 0);
    add_cmd(skt_pkg::ACT_CLEAR, 0, 0);
    add_cmd(skt_pkg::ACT_CLEAR, 0, 0);
    add_cmd(3'd6, '1, 1);
    add_cmd(3'd7, 0, 0);

    for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};

    // random: snapshots over a small key pool so keys recur
    n = 0;
    while (n < 630) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        add_cmd(skt_pkg::ACT_ARM,
                (r == 0 && $urandom_range(0, 1) != 0) ? owner : {$urandom, $urandom}, 0);
        n++;
      end else if (r == 1) begin
        add_cmd(3'($urandom_range(5, 7)), {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        n++;
      end else begin
        for (int j = $urandom_range(0, 12); j > 0; j--) begin
          k = ($urandom_range(0, 15) == 0) ? 64'h0 : key_pool[$urandom_range(0, 23)];
          add_cmd(skt_pkg::ACT_SCAN, k, $urandom_range(0, 3) != 0);
          n++;
        end
        add_cmd(skt_pkg::ACT_END, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                $urandom_range(0, 9) == 0);
        n++;
        for (int j = $urandom_range(0, 5); j > 0; j--) begin
          k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                          : key_pool[$urandom_range(0, 23)];
          add_cmd($urandom_range(0, 3) == 0 ? skt_pkg::ACT_REMOVE : skt_pkg::ACT_QUERY, k,
                  1'($urandom_range(0, 1)));
          n++;
        end
      end
    end

    // fill the current table past its cap once, after a fresh arm
    add_cmd(skt_pkg::ACT_ARM, 64'hfeed_0000_0000_0001, 0, 1);
    for (int i = 1; i <= DEPTH + 2; i++)
      add_cmd(skt_pkg::ACT_SCAN, 64'hc000_0000_0000_0000 + 64'(i), 1);
    add_cmd(skt_pkg::ACT_SCAN, 64'hc000_0000_0000_0001, 0);
    add_cmd(skt_pkg::ACT_END, 0, 0);
    add_cmd(skt_pkg::ACT_QUERY, 64'hc000_0000_0000_0001, 0);

    repeat (5) @(posedge clk);
    rst <= 0;
    wait (cmd_q.size() == 0);
    @(posedge clk);
    wait (!start && expected_words.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_ram.sv
hw/rtl/snapshot_new_key_tracker.sv
test/snapshot_new_key_tracker_tb.sv
